// ===== hw/rtl/sfr_pkg.sv =====
// sfr_pkg: shared widths, register codes, sequencer states and the
// status/control structs passed between the window cells and the sequencer.
// No dependencies.
package sfr_pkg;

  localparam int BYTE_W          = 8;
  localparam int LEN_W           = 4;   // holds lengths and counts 0..8
  localparam int CFG_W           = 64;
  localparam int CFG_IDX_W       = 2;
  localparam int MAX_PATTERN_DEF = 8;
  localparam int MAX_REPLACEMENT = 8;
  localparam int REP_W           = MAX_REPLACEMENT * BYTE_W;
  localparam int REP_IDX_W       = $clog2(MAX_REPLACEMENT);
  localparam int MAX_RESULTS     = 8;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES      = 2'd0,
    REG_PATTERN_LENGTH     = 2'd1,
    REG_REPLACEMENT_BYTES  = 2'd2,
    REG_REPLACEMENT_LENGTH = 2'd3
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_MATCH  = 4'b0100,
    ST_FINISH = 4'b1000
  } seq_state_t;

  // window status seen by the sequencer
  typedef struct packed {
    logic [BYTE_W-1:0] head;  // byte in cell 0
    logic              m0;    // window matches pattern from cell 0
    logic              m1;    // window matches pattern from cell 1
  } win_stat_t;

  // window control driven by the sequencer
  typedef struct packed {
    logic             shift;  // every cell takes its right neighbor's byte
    logic             load;   // new word written behind the held bytes
    logic [LEN_W-1:0] cnt;    // bytes currently in the window
  } win_ctl_t;

endpackage

// ===== hw/rtl/stream_find_replace.sv =====
// stream_find_replace: top level. Configuration registers, the row of
// window cells and the scan sequencer.
// Depends on sfr_pkg, sfr_cell, sfr_seq.
//
// Usage: text bytes enter on in_byte/in_last with in_valid/in_stall; a word
// is taken at a clock edge with in_valid high and in_stall low. Results leave
// on out_byte/out_valid/out_last with res_valid/res_stall, at most one per cycle, held while res_stall is high.
// Every leftmost, non-overlapping occurrence of the pattern (1..8 bytes) is
// replaced by the replacement (0..8 bytes); bytes that may still start a
// match stay in the window cells until decided. The word marked last
// flushes the window; its final result carries out_last, or a bare end
// marker (out_valid 0) is sent when nothing else is produced.
// Throughput: one word per cycle for plain bytes and held match starts while
// results do not back up; a word that completes a match is held while the
// window shifts out the pattern one cell per cycle and the replacement is
// sent, one that breaks a partial match while the bytes it releases are sent,
// and the end of a text while its end marker is sent. The output register
// frees the input as soon as its word is taken, so res_stall holds up the
// input only when results back up. Reset clears the window, sets the pattern
// length to one and the other registers to zero.
module stream_find_replace #(
  parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfr_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [sfr_pkg::BYTE_W-1:0]     in_byte,
  input  logic                           in_last,
  output logic                           res_valid,
  input  logic                           res_stall,
  output logic [sfr_pkg::BYTE_W-1:0]     out_byte,
  output logic                           out_valid,
  output logic                           out_last
);

  localparam int LW    = sfr_pkg::LEN_W;
  localparam int BW    = sfr_pkg::BYTE_W;
  localparam int PAT_W = MAX_PATTERN * BW;

  logic [PAT_W-1:0]         pat;
  logic [LW-1:0]            plen_reg, rlen_reg;
  logic [sfr_pkg::REP_W-1:0] rep;
  logic [LW-1:0]            plen_eff, rlen_eff, span, lim_head, load_pos;

  sfr_pkg::win_stat_t stat;
  sfr_pkg::win_ctl_t  ctl;

  logic [BW-1:0]      win   [MAX_PATTERN];
  logic [MAX_PATTERN:0] ok_head, ok_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pat      <= '0;
      plen_reg <= LW'(1);
      rep      <= '0;
      rlen_reg <= '0;
    end else if (cfg_we) begin
      unique case (sfr_pkg::cfg_reg_t'(cfg_index))
        sfr_pkg::REG_PATTERN_BYTES:      pat      <= cfg_data[PAT_W-1:0];
        sfr_pkg::REG_PATTERN_LENGTH:     plen_reg <= cfg_data[LW-1:0];
        sfr_pkg::REG_REPLACEMENT_BYTES:  rep      <= cfg_data[sfr_pkg::REP_W-1:0];
        sfr_pkg::REG_REPLACEMENT_LENGTH: rlen_reg <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  // clamped lengths and the number of steps a match takes
  assign plen_eff = (plen_reg == '0) ? LW'(1) :
                    (plen_reg > LW'(MAX_PATTERN)) ? LW'(MAX_PATTERN) : plen_reg;
  assign rlen_eff = (rlen_reg > LW'(sfr_pkg::MAX_REPLACEMENT)) ?
                    LW'(sfr_pkg::MAX_REPLACEMENT) : rlen_reg;
  assign span     = (plen_eff > rlen_eff) ? plen_eff : rlen_eff;

  // compare span from cell 0, and the tail cell for a new word
  assign lim_head = (ctl.cnt < plen_eff) ? ctl.cnt : plen_eff;
  assign load_pos = ctl.cnt - LW'(ctl.shift);

  assign ok_head[0] = 1'b1;
  assign ok_next[0] = 1'b1;

  // row of window cells
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    logic [BW-1:0] right_byte, pat_left;

    if (i == MAX_PATTERN - 1) begin : g_tail
      assign right_byte = win[i];
    end else begin : g_mid
      assign right_byte = win[i+1];
    end

    if (i == 0) begin : g_first
      assign pat_left = '0;
    end else begin : g_rest
      assign pat_left = pat[(i-1)*BW +: BW];
    end

    sfr_cell u_cell (
      .clk         (clk),
      .shift       (ctl.shift),
      .load        (ctl.load && (load_pos == LW'(i))),
      .load_byte   (in_byte),
      .right_byte  (right_byte),
      .pat_here    (pat[i*BW +: BW]),
      .pat_left    (pat_left),
      .en_head     (LW'(i) < lim_head),
      .en_next     ((i != 0) && (LW'(i) < ctl.cnt)),
      .ok_head_in  (ok_head[i]),
      .ok_next_in  (ok_next[i]),
      .cell_byte   (win[i]),
      .ok_head_out (ok_head[i+1]),
      .ok_next_out (ok_next[i+1])
    );
  end

  assign stat.head = win[0];
  assign stat.m0   = ok_head[MAX_PATTERN];
  assign stat.m1   = ok_next[MAX_PATTERN];

  // scan sequencer and output register
  sfr_seq #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_last   (in_last),
    .in_stall  (in_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .out_byte  (out_byte),
    .out_valid (out_valid),
    .out_last  (out_last),
    .plen      (plen_eff),
    .rlen      (rlen_eff),
    .span      (span),
    .rep_bytes (rep),
    .stat      (stat),
    .ctl       (ctl)
  );

endmodule

// ===== hw/rtl/sfr_cell.sv =====
// sfr_cell: one byte cell of the match window. Holds a byte, loads or shifts left,
// and extends the two running compare chains (pattern at cell 0 and at cell 1).
// Depends on sfr_pkg.
module sfr_cell (
  input  logic                      clk,
  input  logic                      shift,
  input  logic                      load,
  input  logic [sfr_pkg::BYTE_W-1:0] load_byte,
  input  logic [sfr_pkg::BYTE_W-1:0] right_byte,
  input  logic [sfr_pkg::BYTE_W-1:0] pat_here,
  input  logic [sfr_pkg::BYTE_W-1:0] pat_left,
  input  logic                      en_head,
  input  logic                      en_next,
  input  logic                      ok_head_in,
  input  logic                      ok_next_in,
  output logic [sfr_pkg::BYTE_W-1:0] cell_byte,
  output logic                      ok_head_out,
  output logic                      ok_next_out
);

  // byte storage: load wins over shift for the tail cell
  always_ff @(posedge clk) begin
    if (load) begin
      cell_byte <= load_byte;
    end else if (shift) begin
      cell_byte <= right_byte;
    end
  end

  // compare chains; a disabled cell passes the chain through
  assign ok_head_out = ok_head_in && (!en_head || (cell_byte == pat_here));
  assign ok_next_out = ok_next_in && (!en_next || (cell_byte == pat_left));

endmodule

// ===== hw/rtl/sfr_seq.sv =====
// sfr_seq: scan sequencer for the find/replace window, with the held-back
// result for final texts and the output register.
// Depends on sfr_pkg.
module sfr_seq #(
  parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_last,
  output logic                        in_stall,
  output logic                        res_valid,
  input  logic                        res_stall,
  output logic [sfr_pkg::BYTE_W-1:0]  out_byte,
  output logic                        out_valid,
  output logic                        out_last,
  input  logic [sfr_pkg::LEN_W-1:0]   plen,
  input  logic [sfr_pkg::LEN_W-1:0]   rlen,
  input  logic [sfr_pkg::LEN_W-1:0]   span,
  input  logic [sfr_pkg::REP_W-1:0]   rep_bytes,
  input  sfr_pkg::win_stat_t          stat,
  output sfr_pkg::win_ctl_t           ctl
);

  localparam int LW = sfr_pkg::LEN_W;
  localparam int BW = sfr_pkg::BYTE_W;

  sfr_pkg::seq_state_t state, state_next;
  logic [LW-1:0] cnt;
  logic [LW-1:0] step;
  logic [LW-1:0] emit_cnt;
  logic          item_last;
  logic          pend_v;
  logic [BW-1:0] pend_byte;

  logic [BW-1:0] rep_arr [sfr_pkg::MAX_REPLACEMENT];
  logic [LW-1:0] step_cur;
  logic          out_free, sat;
  logic          stop_head, stop_next, full;
  logic          in_match, plain;
  logic          emit_req, emit_eff, emit_ok, shift_req;
  logic [BW-1:0] emit_byte;
  logic          act_fire, final_step, post_stop;
  logic          end_fire, finish_fire, accept_ok, take, shift, out_load;

  // replacement bytes as an array
  for (genvar r = 0; r < sfr_pkg::MAX_REPLACEMENT; r++) begin : g_rep
    assign rep_arr[r] = rep_bytes[r*BW +: BW];
  end

  // decisions at the head of the window
  assign out_free  = !res_valid || !res_stall;
  assign sat       = (emit_cnt == LW'(sfr_pkg::MAX_RESULTS));
  assign stop_head = (cnt == '0) || (!item_last && (cnt < plen) && stat.m0);
  assign stop_next = (cnt == LW'(1)) ||
                     (!item_last && ((cnt - LW'(1)) < plen) && stat.m1);
  assign full      = (cnt >= plen) && stat.m0;

  assign in_match  = (state == sfr_pkg::ST_MATCH) ||
                     ((state == sfr_pkg::ST_SCAN) && !stop_head && full);
  assign plain     = (state == sfr_pkg::ST_SCAN) && !stop_head && !full;
  assign step_cur  = (state == sfr_pkg::ST_MATCH) ? step : '0;

  // one action per cycle while the output can take it: a plain byte, or one step of a match
  assign emit_req  = plain || (in_match && (step_cur < rlen));
  assign emit_byte = plain ? stat.head : rep_arr[step_cur[sfr_pkg::REP_IDX_W-1:0]];
  assign shift_req = plain || (in_match && (step_cur < plen));
  assign emit_eff  = emit_req && !sat;
  assign emit_ok   = item_last ? (!pend_v || out_free) : out_free;
  assign act_fire  = (plain || in_match) && (!emit_eff || emit_ok);
  assign final_step = plain || ((step_cur + LW'(1)) >= span);
  assign post_stop = shift_req ? stop_next : stop_head;

  // item boundaries and the input handshake
  assign end_fire    = ((state == sfr_pkg::ST_SCAN) && stop_head) ||
                       (act_fire && final_step && post_stop);
  assign finish_fire = (state == sfr_pkg::ST_FINISH) && out_free;
  assign accept_ok   = (state == sfr_pkg::ST_IDLE) || (end_fire && !item_last) ||
                       finish_fire;
  assign in_stall    = !accept_ok;
  assign take        = in_valid && accept_ok;
  assign shift       = act_fire && shift_req;
  assign out_load    = (act_fire && emit_eff && (!item_last || pend_v)) || finish_fire;

  assign ctl.shift = shift;
  assign ctl.load  = take;
  assign ctl.cnt   = cnt;

  // next state
  always_comb begin
    state_next = state;
    unique case (state) inside
      sfr_pkg::ST_IDLE: begin
        if (take) state_next = sfr_pkg::ST_SCAN;
      end
      sfr_pkg::ST_SCAN, sfr_pkg::ST_MATCH: begin
        if (end_fire) begin
          if (item_last) state_next = sfr_pkg::ST_FINISH;
          else state_next = take ? sfr_pkg::ST_SCAN : sfr_pkg::ST_IDLE;
        end else if (act_fire) begin
          state_next = final_step ? sfr_pkg::ST_SCAN : sfr_pkg::ST_MATCH;
        end
      end
      sfr_pkg::ST_FINISH: begin
        if (finish_fire) state_next = take ? sfr_pkg::ST_SCAN : sfr_pkg::ST_IDLE;
      end
      default: state_next = sfr_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sfr_pkg::ST_IDLE;
      cnt       <= '0;
      step      <= '0;
      emit_cnt  <= '0;
      item_last <= 1'b0;
      pend_v    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt - LW'(shift) + LW'(take);
      if (act_fire) step <= final_step ? '0 : step_cur + LW'(1);
      if (take) begin
        item_last <= in_last;
        emit_cnt  <= '0;
      end else if (act_fire && emit_eff) begin
        emit_cnt <= emit_cnt + LW'(1);
      end
      if (finish_fire) pend_v <= 1'b0;
      else if (act_fire && emit_eff && item_last) pend_v <= 1'b1;
      if (out_load) res_valid <= 1'b1;
      else if (!res_stall) res_valid <= 1'b0;
    end
  end

  // payload registers: held-back word and output word
  always_ff @(posedge clk) begin
    if (act_fire && emit_eff && item_last) pend_byte <= emit_byte;
    if (out_load) begin
      if (finish_fire) begin
        out_byte  <= pend_v ? pend_byte : '0;
        out_valid <= pend_v;
        out_last  <= 1'b1;
      end else begin
        out_byte  <= item_last ? pend_byte : emit_byte;
        out_valid <= 1'b1;
        out_last  <= 1'b0;
      end
    end
  end

  // window never overfills
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= LW'(MAX_PATTERN))
    else $error("window count beyond its cells");

  // a held-back word only exists for a final text
  a_pend_last: assert property (@(posedge clk) disable iff (rst)
    pend_v |-> item_last)
    else $error("held-back word outside a final text");

  // no shift out of an empty window
  a_shift_nonempty: assert property (@(posedge clk) disable iff (rst)
    shift |-> (cnt != '0))
    else $error("shift with empty window");

  // the end marker phase belongs to a final text
  a_finish_last: assert property (@(posedge clk) disable iff (rst)
    (state == sfr_pkg::ST_FINISH) |-> item_last)
    else $error("finish phase without final text");

  // an accepted word lands in the window and starts a scan, never a finish phase
  a_take_load: assert property (@(posedge clk) disable iff (rst)
    take |=> (cnt != '0) && (state == sfr_pkg::ST_SCAN))
    else $error("accepted word not in window");

endmodule
